>>> rtl/pidpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidpc_pkg
// Register indexes, field widths and fixed limits of the position controller.
// ----------------------------------------------------------------------------
package pidpc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SETPOINT = 3'd0;
  localparam cfg_idx_t REG_KP       = 3'd1;
  localparam cfg_idx_t REG_KI       = 3'd2;
  localparam cfg_idx_t REG_KD       = 3'd3;
  localparam cfg_idx_t REG_ENABLE   = 3'd4;
  localparam cfg_idx_t REG_MODE     = 3'd5;

  localparam logic signed [16:0] INTEGRAL_WINDOW = 17'sd50;
  localparam logic [22:0]        DRIVE_MAX       = 23'd8388607;
  // largest drive magnitude whose command stays inside the clamp
  localparam logic [22:0]        DRIVE_CMD_KNEE  = 23'd635;
  localparam logic [10:0]        COMMAND_LIMIT   = 11'd1280;

  localparam logic [15:0] KP_RESET = 16'd256;
  localparam logic [7:0]  KI_RESET = 8'd51;
  localparam logic [15:0] KD_RESET = 16'd256;

endpackage

`default_nettype wire

>>> rtl/pid_position_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_position_controller
// Position loop with windowed integral, derivative and clamped command output.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle unless the input is stalled. Its result
// is presented on the outputs behind two register stages: the first holds the
// three gain products, the second the drive and command. The error, integral
// and previous error state close their loop in the cycle of the input transfer,
// so samples may follow each other in every cycle. Input stalls only while the
// product stage is full and the held result is stalled. Configuration is applied
// to the next sample taken. Configuration is to be written only while no sample
// is in flight; the block itself does not enforce this.
module pid_position_controller (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration write channel
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [pidpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pidpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // sample channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  signed [15:0]                  in_measured_position,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [23:0]                  out_drive,
  output logic signed [11:0]                  out_command,
  output logic                                out_command_is_accel,
  output logic signed [16:0]                  out_error_value,
  output logic signed [18:0]                  out_derivative_value
);

  // configuration registers
  logic signed [15:0] setpoint_r;
  logic [15:0]        kp_r;
  logic [7:0]         ki_r;
  logic [15:0]        kd_r;
  logic               run_enable_r;
  logic               output_mode_r;

  // loop state
  logic signed [16:0] prev_err_r, prev_err_nxt;
  logic signed [31:0] integ_r, integ_nxt;

  // product stage
  logic               s1_valid_r;
  logic signed [34:0] pp_r;
  logic signed [40:0] pi_r;
  logic signed [35:0] pd_r;
  logic signed [16:0] s1_err_r;
  logic signed [18:0] s1_deriv_r;
  logic               s1_mode_r;

  logic in_xfer, s1_advance, res_free;

  assign cfg_ready  = 1'b1;
  assign res_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid_r && res_free;
  assign in_stall   = s1_valid_r && !res_free;
  assign in_xfer    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r    <= '0;
      kp_r          <= pidpc_pkg::KP_RESET;
      ki_r          <= pidpc_pkg::KI_RESET;
      kd_r          <= pidpc_pkg::KD_RESET;
      run_enable_r  <= 1'b1;
      output_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pidpc_pkg::REG_SETPOINT: setpoint_r    <= $signed(cfg_data[15:0]);
        pidpc_pkg::REG_KP:       kp_r          <= cfg_data[15:0];
        pidpc_pkg::REG_KI:       ki_r          <= cfg_data[7:0];
        pidpc_pkg::REG_KD:       kd_r          <= cfg_data[15:0];
        pidpc_pkg::REG_ENABLE:   run_enable_r  <= cfg_data[0];
        pidpc_pkg::REG_MODE:     output_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---- error, integral and derivative of the incoming sample
  logic signed [16:0] err;
  logic signed [32:0] integ_sum;
  logic signed [31:0] integ_sat;
  logic               in_window;
  logic signed [17:0] err_diff;
  logic signed [18:0] deriv;
  logic signed [34:0] pp;
  logic signed [40:0] pi;
  logic signed [35:0] pd;

  always_comb begin
    err       = {in_measured_position[15], in_measured_position}
              - {setpoint_r[15], setpoint_r};
    in_window = (err < pidpc_pkg::INTEGRAL_WINDOW) && (err > -pidpc_pkg::INTEGRAL_WINDOW);
    integ_sum = {integ_r[31], integ_r} + {{16{err[16]}}, err};
    if (integ_sum[32] != integ_sum[31]) begin
      integ_sat = integ_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      integ_sat = integ_sum[31:0];
    end
    err_diff = {err[16], err} - {prev_err_r[16], prev_err_r};
    deriv    = {err_diff, 1'b0};

    if (!run_enable_r) begin
      // disabled: state clears and drive, command, error and derivative are zero
      integ_nxt    = '0;
      prev_err_nxt = '0;
      err          = '0;
      deriv        = '0;
    end else begin
      integ_nxt    = in_window ? integ_sat : 32'sd0;
      prev_err_nxt = err;
    end

    pp = $signed({1'b0, kp_r}) * err;
    pi = $signed({1'b0, ki_r}) * integ_nxt;
    pd = $signed({1'b0, kd_r}) * deriv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        prev_err_r <= prev_err_nxt;
        integ_r    <= integ_nxt;
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pp_r       <= pp;
      pi_r       <= pi;
      pd_r       <= pd;
      s1_err_r   <= err;
      s1_deriv_r <= deriv;
      s1_mode_r  <= output_mode_r;
    end
  end

  // ---- drive and command
  logic signed [42:0] acc;
  logic [42:0]        acc_mag;
  logic [34:0]        mag_int;
  logic [22:0]        mag_sat;
  logic               err_neg;
  logic signed [23:0] drive;
  logic [10:0]        twice_mag;
  logic [11:0]        twice_mag_p1;
  logic [19:0]        recip_prod;
  logic [10:0]        cmd_q;
  logic [10:0]        cmd_mag;
  logic signed [11:0] command;

  always_comb begin
    acc     = {{8{pp_r[34]}}, pp_r} + {{2{pi_r[40]}}, pi_r} + {{7{pd_r[35]}}, pd_r};
    acc_mag = acc[42] ? 43'(-acc) : acc;
    mag_int = acc_mag[42:8];
    mag_sat = (mag_int > 35'(pidpc_pkg::DRIVE_MAX)) ? pidpc_pkg::DRIVE_MAX : mag_int[22:0];
    err_neg = s1_err_r[16];
    drive   = err_neg ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

    // mag*256/127 = 2*mag + floor(2*mag/127); the last term via (t+1)*129 >> 14
    twice_mag    = {mag_sat[9:0], 1'b0};
    twice_mag_p1 = {1'b0, twice_mag} + 12'd1;
    recip_prod   = {twice_mag_p1, 7'd0} + {8'd0, twice_mag_p1};
    cmd_q        = twice_mag + {5'd0, recip_prod[19:14]};
    cmd_mag      = (mag_sat > pidpc_pkg::DRIVE_CMD_KNEE) ? pidpc_pkg::COMMAND_LIMIT : cmd_q;
    // command has the opposite sign to the drive
    command      = err_neg ? $signed({1'b0, cmd_mag}) : -$signed({1'b0, cmd_mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_drive            <= drive;
      out_command          <= command;
      out_command_is_accel <= s1_mode_r;
      out_error_value      <= s1_err_r;
      out_derivative_value <= s1_deriv_r;
    end
  end

  // ---- assertions
  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_command <= 12'sd1280) && (out_command >= -12'sd1280))
    else $error("command outside clamp");

  a_cmd_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_drive != 24'sd0)) |-> (out_command[11] != out_drive[23]))
    else $error("command sign does not oppose drive");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid))
    else $error("input stalled with product stage free");

  a_disable_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !run_enable_r) |=> ((prev_err_r == 17'sd0) && (integ_r == 32'sd0)))
    else $error("state not cleared while disabled");

endmodule

`default_nettype wire

>>> tb/sv/pid_position_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_controller_test
// Self-checking bench for the position controller. A behavioural predictor
// keeps its own error, integral and gain state and works out drive, command,
// mode tag, error and derivative for every accepted sample. Each result
// transfer is checked field by field. Directed cases cover the reset gains,
// the integral window edges, drive and command saturation, disable and
// unmapped register writes. They are followed by random phases with random
// gains and setpoints, and random input gaps and result stalls.
// ----------------------------------------------------------------------------
module pid_position_controller_test;

  localparam pidpc_pkg::cfg_idx_t REG_UNUSED_A = 3'd6;
  localparam pidpc_pkg::cfg_idx_t REG_UNUSED_B = 3'd7;

  localparam longint WINDOW      = 50;
  localparam longint DRIVE_LIMIT = 8388607;
  localparam longint CMD_LIMIT   = 1280;
  localparam longint CMD_DIVISOR = 127;

  localparam int RANDOM_SAMPLES = 900;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic signed [23:0] drive;
    logic signed [11:0] command;
    logic               command_is_accel;
    logic signed [16:0] error_value;
    logic signed [18:0] derivative_value;
  } control_output_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_valid;
  logic                             cfg_ready;
  pidpc_pkg::cfg_idx_t              cfg_index;
  logic [pidpc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  logic signed [15:0]               in_measured_position;
  logic                             out_valid;
  logic                             out_stall;
  logic signed [23:0]               out_drive;
  logic signed [11:0]               out_command;
  logic                             out_command_is_accel;
  logic signed [16:0]               out_error_value;
  logic signed [18:0]               out_derivative_value;

  // predictor copy of the registers and loop state
  logic signed [15:0] setpoint_q;
  logic [15:0]        kp_q;
  logic [7:0]         ki_q;
  logic [15:0]        kd_q;
  logic               enable_q;
  logic               mode_q;
  logic signed [16:0] prev_error_q;
  logic signed [31:0] integral_q;

  control_output_t control_outputs_due[$];
  control_output_t head_output;
  int              fail_count = 0;
  bit              pace_busy = 1'b0;
  int              stall_left = 0;

  pid_position_controller u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_measured_position (in_measured_position),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_drive            (out_drive),
    .out_command          (out_command),
    .out_command_is_accel (out_command_is_accel),
    .out_error_value      (out_error_value),
    .out_derivative_value (out_derivative_value)
  );

  always #2 clk = ~clk;

  // mostly no gap, some short ones, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void apply_reg(input pidpc_pkg::cfg_idx_t idx,
                                    input logic [15:0] data);
    case (idx)
      pidpc_pkg::REG_SETPOINT: setpoint_q = data;
      pidpc_pkg::REG_KP:       kp_q = data;
      pidpc_pkg::REG_KI:       ki_q = data[7:0];
      pidpc_pkg::REG_KD:       kd_q = data;
      pidpc_pkg::REG_ENABLE:   enable_q = data[0];
      pidpc_pkg::REG_MODE:     mode_q = data[0];
      default: ;
    endcase
  endfunction

  function automatic control_output_t predict_control_output(
    input logic signed [15:0] pos
  );
    longint          err, deriv, acc, mag, drv, cmd, sum;
    control_output_t r;
    r = '0;
    r.command_is_accel = mode_q;
    if (!enable_q) begin
      prev_error_q = '0;
      integral_q   = '0;
      return r;
    end
    err = longint'(pos) - longint'(setpoint_q);
    // integral only runs inside the window, saturating at 32 bits
    if (err < WINDOW && err > -WINDOW) begin
      sum = longint'(integral_q) + err;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      integral_q = sum[31:0];
    end else begin
      integral_q = '0;
    end
    deriv = 2 * (err - longint'(prev_error_q));
    prev_error_q = err[16:0];
    acc = longint'(kp_q) * err + longint'(ki_q) * longint'(integral_q)
        + longint'(kd_q) * deriv;
    mag = (acc < 0) ? -acc : acc;
    mag = mag / 256;
    if (mag > DRIVE_LIMIT) mag = DRIVE_LIMIT;
    // zero error counts as positive
    drv = (err < 0) ? -mag : mag;
    cmd = -(drv * 256) / CMD_DIVISOR;
    if (cmd > CMD_LIMIT) cmd = CMD_LIMIT;
    if (cmd < -CMD_LIMIT) cmd = -CMD_LIMIT;
    r.drive            = drv[23:0];
    r.command          = cmd[11:0];
    r.error_value      = err[16:0];
    r.derivative_value = deriv[18:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (control_outputs_due.size() == 0) begin
        $error("result transfer with no sample pending");
        fail_count++;
      end else begin
        head_output = control_outputs_due.pop_front();
        check_field("drive", head_output.drive, out_drive);
        check_field("command", head_output.command, out_command);
        check_field("command_is_accel", head_output.command_is_accel,
                    out_command_is_accel);
        check_field("error_value", head_output.error_value, out_error_value);
        check_field("derivative_value", head_output.derivative_value,
                    out_derivative_value);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n || !pace_busy) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_length();
    end
  end

  // leaves in_valid high after the transfer; the caller sends again or drains
  task automatic send_position(input logic signed [15:0] pos);
    int gap;
    gap = pace_busy ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_measured_position <= pos;
    do @(posedge clk); while (in_stall);
    control_outputs_due.push_back(predict_control_output(pos));
  endtask

  task automatic wait_results_in();
    in_valid <= 1'b0;
    while (control_outputs_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input pidpc_pkg::cfg_idx_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  // unused upper bits of the narrow registers carry random junk
  task automatic configure(input logic signed [15:0] sp, input logic [15:0] kp,
                           input logic [7:0] ki, input logic [15:0] kd,
                           input logic en, input logic mode);
    write_reg(pidpc_pkg::REG_SETPOINT, sp);
    write_reg(pidpc_pkg::REG_KP, kp);
    write_reg(pidpc_pkg::REG_KI, {8'($urandom), ki});
    write_reg(pidpc_pkg::REG_KD, kd);
    write_reg(pidpc_pkg::REG_ENABLE, {15'($urandom), en});
    write_reg(pidpc_pkg::REG_MODE, {15'($urandom), mode});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'($urandom_range(0, 1023));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_setpoint();
    case ($urandom_range(0, 5))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly near the setpoint so the integral window is exercised
  function automatic logic signed [15:0] pick_position(input logic signed [15:0] sp);
    int p;
    if ($urandom_range(0, 9) < 7) begin
      p = int'(sp) + int'($urandom_range(0, 120)) - 60;
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
    end else begin
      p = $urandom;
    end
    return p[15:0];
  endfunction

  task automatic test_reset_defaults();
    send_position(16'sd0);
    send_position(16'sd10);
    send_position(-16'sd10);
    send_position(16'sd49);
    send_position(-16'sd49);
    send_position(16'sd50);
    send_position(-16'sd50);
    send_position(16'sd0);
    wait_results_in();
  endtask

  task automatic test_saturation();
    configure(-16'sd32768, 16'hffff, 8'hff, 16'hffff, 1'b1, 1'b0);
    send_position(16'sd32767);
    send_position(-16'sd32768);
    wait_results_in();
    configure(16'sd32767, 16'hffff, 8'h00, 16'h0000, 1'b1, 1'b1);
    send_position(-16'sd32768);
    send_position(16'sd32767);
    wait_results_in();
    configure(16'sd0, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b0);
    send_position(16'sd1234);
    wait_results_in();
  endtask

  task automatic test_integral_window();
    configure(16'sd100, 16'h0010, 8'hff, 16'h0000, 1'b1, 1'b0);
    send_position(16'sd149);
    send_position(16'sd149);
    send_position(16'sd51);
    send_position(16'sd150);
    send_position(16'sd148);
    send_position(16'sd100);
    wait_results_in();
  endtask

  task automatic test_disable();
    configure(16'sd0, pidpc_pkg::KP_RESET, pidpc_pkg::KI_RESET,
              pidpc_pkg::KD_RESET, 1'b0, 1'b1);
    send_position(16'sd300);
    send_position(-16'sd300);
    wait_results_in();
    configure(16'sd0, pidpc_pkg::KP_RESET, pidpc_pkg::KI_RESET,
              pidpc_pkg::KD_RESET, 1'b1, 1'b1);
    send_position(16'sd20);
    wait_results_in();
  endtask

  task automatic test_unused_registers();
    write_reg(REG_UNUSED_A, 16'($urandom));
    write_reg(REG_UNUSED_B, 16'($urandom));
    cfg_valid <= 1'b0;
    send_position(16'sd7);
    wait_results_in();
  endtask

  task automatic test_random_traffic();
    int                 sent;
    int                 phase_len;
    logic signed [15:0] sp;
    logic [7:0]         ki;
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      wait_results_in();
      sp = pick_setpoint();
      case ($urandom_range(0, 9))
        0:       ki = 8'h00;
        1:       ki = 8'hff;
        default: ki = 8'($urandom);
      endcase
      configure(sp, pick_gain(), ki, pick_gain(), $urandom_range(0, 7) != 0,
                1'($urandom));
      pace_busy = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 80);
      for (int i = 0; i < phase_len; i++) begin
        // now and then hold off until the pipeline has emptied
        if ($urandom_range(0, 59) == 0) wait_results_in();
        send_position(pick_position(sp));
        sent++;
      end
    end
    pace_busy = 1'b0;
  endtask

  initial begin
    rst_n                <= 1'b0;
    cfg_valid            <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    in_valid             <= 1'b0;
    in_measured_position <= '0;
    out_stall            <= 1'b0;
    setpoint_q   = '0;
    kp_q         = pidpc_pkg::KP_RESET;
    ki_q         = pidpc_pkg::KI_RESET;
    kd_q         = pidpc_pkg::KD_RESET;
    enable_q     = 1'b1;
    mode_q       = 1'b0;
    prev_error_q = '0;
    integral_q   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_saturation();
    test_integral_window();
    pace_busy = 1'b1;
    test_disable();
    test_unused_registers();
    pace_busy = 1'b0;
    test_random_traffic();

    wait_results_in();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("pid_position_controller_test OK");
    end else begin
      $display("pid_position_controller_test NOT OK");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("pid_position_controller_test NOT OK");
    $finish;
  end

endmodule
